// ===== hw/rtl/scdg_pkg.sv =====
// ----------------------------------------------------------------------------
// scdg_pkg: shared types and constants for the sidechain ducking gain core
// Field widths, command and register codes, reset values, item struct.
// ----------------------------------------------------------------------------
package scdg_pkg;

   localparam int GainW   = 17;   // Q1.16 gain, 65536 is unity
   localparam int SampleW = 16;   // Q1.15 key sample
   localparam int ThrW    = 15;
   localparam int TimeW   = 16;
   localparam int FrameW  = 13;
   localparam int CmdW    = 2;
   localparam int CsrIdxW = 2;
   localparam int ProdW   = GainW + FrameW;          // rate * frames
   localparam int DivCntW = $clog2(GainW + 1);

   localparam logic [GainW-1:0]  UnityGain = GainW'(65536);
   localparam logic [GainW-1:0]  RateFloor = GainW'(328);  // 0.005 in Q1.16
   localparam logic [FrameW-1:0] MaxFrames = FrameW'(4096);
   localparam logic [ThrW-1:0]   ThresholdReset = ThrW'(32767);
   localparam logic [DivCntW-1:0] DivSteps = DivCntW'(GainW);

   // command codes
   localparam logic [CmdW-1:0] CmdKey   = 2'd0;
   localparam logic [CmdW-1:0] CmdGain  = 2'd1;
   localparam logic [CmdW-1:0] CmdForce = 2'd2;

   // register indexes
   localparam logic [CsrIdxW-1:0] RegThreshold  = 2'd0;
   localparam logic [CsrIdxW-1:0] RegStrength   = 2'd1;
   localparam logic [CsrIdxW-1:0] RegAttackTime = 2'd2;
   localparam logic [CsrIdxW-1:0] RegDecayTime  = 2'd3;

   typedef struct packed {
      logic [CmdW-1:0]           cmd;
      logic signed [SampleW-1:0] left_sample;
      logic signed [SampleW-1:0] right_sample;
      logic                      first_of_buffer;
      logic [FrameW-1:0]         frame_count;
      logic                      force_value;
   } req_item_type;

   typedef struct packed {
      logic [ThrW-1:0]  threshold;
      logic [GainW-1:0] strength;
      logic [GainW-1:0] attack_rate;
      logic [GainW-1:0] decay_rate;
   } duck_cfg_type;

endpackage

// ===== hw/rtl/scdg_rate_div.sv =====
// ----------------------------------------------------------------------------
// scdg_rate_div: ramp rate from strength and ramp time
// Restoring divider, one quotient bit per cycle; applies the rate floor.
// ----------------------------------------------------------------------------
module scdg_rate_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [scdg_pkg::GainW-1:0]     dividend,
   input  logic [scdg_pkg::TimeW-1:0]     divisor,
   output logic [scdg_pkg::GainW-1:0]     rate,
   output logic                           busy
);

   logic [scdg_pkg::GainW-1:0]   rate_ff, rate_in;
   logic [scdg_pkg::GainW-1:0]   quo_ff, quo_in;
   logic [scdg_pkg::TimeW-1:0]   rem_ff, rem_in;
   logic [scdg_pkg::TimeW-1:0]   dvs_ff, dvs_in;
   logic [scdg_pkg::DivCntW-1:0] cnt_ff, cnt_in;
   logic [scdg_pkg::TimeW:0]     trial;
   logic [scdg_pkg::TimeW:0]     diff;
   logic                         fits;
   logic [scdg_pkg::GainW-1:0]   quo_step;

   assign trial    = {rem_ff, quo_ff[scdg_pkg::GainW-1]};
   assign diff     = trial - {1'b0, dvs_ff};
   assign fits     = (trial >= {1'b0, dvs_ff});
   assign quo_step = {quo_ff[scdg_pkg::GainW-2:0], fits};

   always_comb begin
      rate_in = rate_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         if (divisor == '0) begin
            // instant ramp: rate is the strength itself, or the rate floor for zero strength
            rate_in = (dividend == '0) ? scdg_pkg::RateFloor : dividend;
            cnt_in  = '0;
         end else begin
            quo_in = dividend;
            rem_in = '0;
            dvs_in = divisor;
            cnt_in = scdg_pkg::DivSteps;
         end
      end else if (cnt_ff != '0) begin
         quo_in = quo_step;
         rem_in = fits ? diff[scdg_pkg::TimeW-1:0] : trial[scdg_pkg::TimeW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 1'b1) begin
            rate_in = (quo_step == '0) ? scdg_pkg::RateFloor : quo_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= scdg_pkg::UnityGain;
         cnt_ff  <= '0;
      end else begin
         rate_ff <= rate_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rate = rate_ff;
   assign busy = (cnt_ff != '0);

endmodule

// ===== hw/rtl/scdg_step.sv =====
// ----------------------------------------------------------------------------
// scdg_step: next gain and key flag for one item
// Key compare, one rate-by-frames multiply, ramp with clamp and saturation.
// ----------------------------------------------------------------------------
module scdg_step (
   input  scdg_pkg::req_item_type       item,
   input  scdg_pkg::duck_cfg_type       cfg,
   input  logic [scdg_pkg::GainW-1:0]   gain_cur,
   input  logic                         above_cur,
   output logic [scdg_pkg::GainW-1:0]   gain_next,
   output logic                         above_next
);

   logic signed [scdg_pkg::SampleW+1:0] key_sum;
   logic signed [scdg_pkg::SampleW+1:0] key_lim;
   logic                                key_hot;
   logic [scdg_pkg::FrameW-1:0]         frames;
   logic                                ramp_down;
   logic                                ramp_up;
   logic [scdg_pkg::GainW-1:0]          rate_sel;
   logic [scdg_pkg::ProdW-1:0]          delta;
   logic [scdg_pkg::GainW-1:0]          gap;
   logic [scdg_pkg::GainW-1:0]          gain_down;
   logic [scdg_pkg::ProdW-1:0]          up_sum;
   logic [scdg_pkg::GainW-1:0]          gain_up;

   // average above threshold, compared as left+right > 2*threshold
   assign key_sum = (scdg_pkg::SampleW+2)'(item.left_sample)
                  + (scdg_pkg::SampleW+2)'(item.right_sample);
   assign key_lim = $signed({2'b00, cfg.threshold, 1'b0});
   assign key_hot = (key_sum > key_lim);

   assign frames = (item.frame_count > scdg_pkg::MaxFrames) ?
                   scdg_pkg::MaxFrames : item.frame_count;

   assign ramp_down = above_cur && (gain_cur > cfg.strength);
   assign ramp_up   = above_cur ? (gain_cur < cfg.strength)
                                : (gain_cur < scdg_pkg::UnityGain);
   assign rate_sel  = ramp_down ? cfg.attack_rate : cfg.decay_rate;
   assign delta     = scdg_pkg::ProdW'(rate_sel) * scdg_pkg::ProdW'(frames);

   assign gap       = gain_cur - cfg.strength;
   assign gain_down = (delta >= scdg_pkg::ProdW'(gap)) ?
                      cfg.strength : (gain_cur - delta[scdg_pkg::GainW-1:0]);

   assign up_sum  = scdg_pkg::ProdW'(gain_cur) + delta;
   assign gain_up = (up_sum > scdg_pkg::ProdW'(scdg_pkg::UnityGain)) ?
                    scdg_pkg::UnityGain : up_sum[scdg_pkg::GainW-1:0];

   always_comb begin
      gain_next  = gain_cur;
      above_next = above_cur;
      case (item.cmd)
         scdg_pkg::CmdKey: begin
            above_next = (above_cur && !item.first_of_buffer) || key_hot;
         end
         scdg_pkg::CmdGain: begin
            if (ramp_down) begin
               gain_next = gain_down;
            end else if (ramp_up) begin
               gain_next = gain_up;
            end
         end
         scdg_pkg::CmdForce: begin
            above_next = item.force_value;
         end
         default: begin
            gain_next  = gain_cur;
            above_next = above_cur;
         end
      endcase
   end

endmodule

// ===== hw/rtl/sidechain_ducking_gain_core.sv =====
// ----------------------------------------------------------------------------
// sidechain_ducking_gain_core: key-driven ducking gain, Q1.16
// Items pass the input register, then the state register that holds results.
// Throughput: one item per cycle when not stalled; gain state feeds back.
// A register write holds off input transfers while the two 17-step rate
// dividers recompute attack and decay rates.
// Reset (synchronous, active high): unity gain, flag clear, rates unity.
// ----------------------------------------------------------------------------
module sidechain_ducking_gain_core (
   input  logic                               clock,
   input  logic                               reset,
   // item channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [scdg_pkg::CmdW-1:0]          req_cmd,
   input  logic signed [scdg_pkg::SampleW-1:0] req_left_sample,
   input  logic signed [scdg_pkg::SampleW-1:0] req_right_sample,
   input  logic                               req_first_of_buffer,
   input  logic [scdg_pkg::FrameW-1:0]        req_frame_count,
   input  logic                               req_force_value,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [scdg_pkg::GainW-1:0]         rsp_gain,
   output logic                               rsp_above_threshold,
   // register write port
   input  logic                               csr_write_enable,
   input  logic [scdg_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [scdg_pkg::GainW-1:0]         csr_write_data
);

   // configuration registers
   logic [scdg_pkg::ThrW-1:0]  threshold_ff;
   logic [scdg_pkg::GainW-1:0] strength_ff;
   logic [scdg_pkg::TimeW-1:0] attack_time_ff;
   logic [scdg_pkg::TimeW-1:0] decay_time_ff;
   logic                       cfg_wr_ff;     // kicks the rate dividers
   logic [scdg_pkg::GainW-1:0] strength_wr;

   // input stage
   logic                       in_valid_ff, in_valid_in;
   scdg_pkg::req_item_type     in_item_ff;
   scdg_pkg::req_item_type     req_item;

   // state; the result register is the state itself, since the state only
   // moves when the result slot is free to take the new value
   logic [scdg_pkg::GainW-1:0] gain_ff;
   logic                       above_ff;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic [scdg_pkg::GainW-1:0] attack_rate;
   logic [scdg_pkg::GainW-1:0] decay_rate;
   logic                       attack_busy;
   logic                       decay_busy;
   logic                       rate_busy;
   scdg_pkg::duck_cfg_type     cfg;
   logic [scdg_pkg::GainW-1:0] gain_next;
   logic                       above_next;
   logic                       advance;
   logic                       accept;

   // strength above unity saturates on write
   assign strength_wr = (csr_write_data > scdg_pkg::UnityGain) ?
                        scdg_pkg::UnityGain : csr_write_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= scdg_pkg::ThresholdReset;
         strength_ff    <= scdg_pkg::UnityGain;
         attack_time_ff <= '0;
         decay_time_ff  <= '0;
         cfg_wr_ff      <= 1'b0;
      end else begin
         cfg_wr_ff <= csr_write_enable;
         if (csr_write_enable) begin
            case (csr_index)
               scdg_pkg::RegThreshold: begin
                  threshold_ff <= csr_write_data[scdg_pkg::ThrW-1:0];
               end
               scdg_pkg::RegStrength: begin
                  strength_ff <= strength_wr;
               end
               scdg_pkg::RegAttackTime: begin
                  attack_time_ff <= csr_write_data[scdg_pkg::TimeW-1:0];
               end
               scdg_pkg::RegDecayTime: begin
                  decay_time_ff <= csr_write_data[scdg_pkg::TimeW-1:0];
               end
               default: begin
                  threshold_ff <= threshold_ff;
               end
            endcase
         end
      end
   end

   // rates = strength / time, recomputed after every register write
   scdg_rate_div u_attack_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cfg_wr_ff),
      .dividend (strength_ff),
      .divisor  (attack_time_ff),
      .rate     (attack_rate),
      .busy     (attack_busy)
   );

   scdg_rate_div u_decay_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cfg_wr_ff),
      .dividend (strength_ff),
      .divisor  (decay_time_ff),
      .rate     (decay_rate),
      .busy     (decay_busy)
   );

   assign rate_busy = csr_write_enable || cfg_wr_ff || attack_busy || decay_busy;

   // handshake: item moves to the state/result register when the result
   // slot is empty or being drained this cycle
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = rate_busy || (in_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;

   assign req_item.cmd             = req_cmd;
   assign req_item.left_sample     = req_left_sample;
   assign req_item.right_sample    = req_right_sample;
   assign req_item.first_of_buffer = req_first_of_buffer;
   assign req_item.frame_count     = req_frame_count;
   assign req_item.force_value     = req_force_value;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign cfg.threshold   = threshold_ff;
   assign cfg.strength    = strength_ff;
   assign cfg.attack_rate = attack_rate;
   assign cfg.decay_rate  = decay_rate;

   scdg_step u_step (
      .item       (in_item_ff),
      .cfg        (cfg),
      .gain_cur   (gain_ff),
      .above_cur  (above_ff),
      .gain_next  (gain_next),
      .above_next (above_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= scdg_pkg::UnityGain;
         above_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            gain_ff  <= gain_next;
            above_ff <= above_next;
         end
      end
      if (accept) begin
         in_item_ff <= req_item;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_gain            = gain_ff;
   assign rsp_above_threshold = above_ff;

   // no item may enter while a rate is still being computed
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (attack_busy || decay_busy) |-> !accept)
      else $error("item transfer while rate divider busy");

   // gain never goes above unity
   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= scdg_pkg::UnityGain)
      else $error("gain above unity");

   // state only changes when an item moves into the result slot
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(gain_ff) && $stable(above_ff)))
      else $error("state changed without an item");

   // a full input stage behind a stalled result must stall the input
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("input taken with both stages full");

endmodule
